// ----- hw/rtl/vmsf_pkg.sv -----
// vmsf_pkg: item and result types and fixed constants for the von Mises
// safety factor unit. No dependencies.
`default_nettype none

package vmsf_pkg;

    localparam int DATA_W    = 32;
    localparam int VM_W      = 33;
    localparam int DIV_STEPS = 32;
    localparam logic [DATA_W-1:0] FACTOR_MAX = '1;

    typedef struct packed {
        logic signed [DATA_W-1:0] stress_xx;
        logic signed [DATA_W-1:0] stress_yy;
        logic signed [DATA_W-1:0] stress_zz;
        logic signed [DATA_W-1:0] shear_xy;
        logic signed [DATA_W-1:0] shear_yz;
        logic signed [DATA_W-1:0] shear_xz;
    } vmsf_item_t;

    typedef struct packed {
        logic [VM_W-1:0]   von_mises;
        logic [DATA_W-1:0] safety_factor;
        logic              unbounded;
    } vmsf_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/von_mises_safety_factor_unit.sv -----
// Von Mises equivalent stress and Q-format safety factor, fully pipelined.
// A result strobes on done once the item has passed the input stages, square
// root, divider and output register. Throughput: one item per cycle.
// The stage count is set by the square root (one root bit per stage) and the
// divider (one quotient bit per stage). The receiver cannot stall; busy is
// high during reset and up to the first clock edge after it. Reset clears
// valid bits and the yield register.
`default_nettype none

module von_mises_safety_factor_unit #(
    parameter int STRESS_BITS   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire vmsf_pkg::vmsf_item_t   stress,
    output logic                        done,
    output vmsf_pkg::vmsf_result_t      result,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [31:0]            cfg_data
);
    import vmsf_pkg::*;

    localparam int SB    = STRESS_BITS;
    localparam int SQ_W  = 2 * SB;          // one squared term
    localparam int RW    = SB + 1;          // root width
    localparam int RAD_W = 2 * RW;          // halved sum width
    localparam int REM_W = RW + 1;          // square root remainder

    // Ready flag: low in reset, high ever after
    logic ready_reg;
    logic [DATA_W-1:0] yield_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
            yield_reg <= '0;
        end
        else
        begin
            ready_reg <= 1'b1;
            if (cfg_valid && cfg_ready)
                yield_reg <= cfg_data;
        end
    end

    assign busy      = !ready_reg;
    assign cfg_ready = ready_reg;

    logic accept;
    assign accept = start && !busy;

    // ---------------------------------------------------------------------
    // Stage 1: sign-extend, form absolute normal differences and shear
    // magnitudes
    // ---------------------------------------------------------------------
    logic          s1_vld_reg;
    logic [SB-1:0] s1_d_reg [3];
    logic [SB-1:0] s1_s_reg [3];

    logic signed [SB:0] xx, yy, zz, dif [3], shr [3];
    logic [SB-1:0]      d_next [3], s_next [3];

    always_comb
    begin
        xx     = (SB+1)'($signed(stress.stress_xx[SB-1:0]));
        yy     = (SB+1)'($signed(stress.stress_yy[SB-1:0]));
        zz     = (SB+1)'($signed(stress.stress_zz[SB-1:0]));
        shr[0] = (SB+1)'($signed(stress.shear_xy[SB-1:0]));
        shr[1] = (SB+1)'($signed(stress.shear_yz[SB-1:0]));
        shr[2] = (SB+1)'($signed(stress.shear_xz[SB-1:0]));
        dif[0] = xx - yy;
        dif[1] = yy - zz;
        dif[2] = zz - xx;
        for (int k = 0; k < 3; k++)
        begin
            d_next[k] = dif[k][SB] ? SB'(-dif[k]) : dif[k][SB-1:0];
            s_next[k] = shr[k][SB] ? SB'(-shr[k]) : shr[k][SB-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: six squares
    // Stage 3: sum normal and shear squares separately
    // Stage 4: total = normals + 6 * shears, halve
    // ---------------------------------------------------------------------
    logic            s2_vld_reg, s3_vld_reg;
    logic [SQ_W-1:0] s2_d_reg [3];
    logic [SQ_W-1:0] s2_s_reg [3];
    logic [SQ_W+1:0] s3_dsum_reg;
    logic [SQ_W-1:0] s3_ssum_reg;
    logic [SQ_W+2:0] total;

    assign total = (SQ_W+3)'(s3_dsum_reg) + ((SQ_W+3)'(s3_ssum_reg) << 2)
                 + ((SQ_W+3)'(s3_ssum_reg) << 1);

    // Square root pipeline, entry 0 is loaded by stage 4
    logic             sq_vld_reg  [RW+1];
    logic [RAD_W-1:0] sq_rad_reg  [RW+1];
    logic [REM_W-1:0] sq_rem_reg  [RW+1];
    logic [RW-1:0]    sq_root_reg [RW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            sq_vld_reg[0] <= 1'b0;
        end
        else
        begin
            s1_vld_reg    <= accept;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            sq_vld_reg[0] <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s1_d_reg[k] <= d_next[k];
            s1_s_reg[k] <= s_next[k];
            s2_d_reg[k] <= s1_d_reg[k] * s1_d_reg[k];
            s2_s_reg[k] <= s1_s_reg[k] * s1_s_reg[k];
        end
        s3_dsum_reg    <= (SQ_W+2)'(s2_d_reg[0]) + (SQ_W+2)'(s2_d_reg[1])
                        + (SQ_W+2)'(s2_d_reg[2]);
        s3_ssum_reg    <= s2_s_reg[0] + s2_s_reg[1] + s2_s_reg[2];
        sq_rad_reg[0]  <= total[SQ_W+2:1];
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
    end

    // ---------------------------------------------------------------------
    // Square root: one root bit per stage, digit-by-digit with remainder
    // ---------------------------------------------------------------------
    for (genvar i = 0; i < RW; i++)
    begin : g_sqrt
        logic [REM_W+1:0] acc;
        logic [REM_W+1:0] trial;
        logic             ge;

        always_comb
        begin
            acc   = {sq_rem_reg[i], sq_rad_reg[i][RAD_W-1-2*i -: 2]};
            trial = (REM_W+2)'({sq_root_reg[i], 2'b01});
            ge    = acc >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[i+1] <= 1'b0;
            else
                sq_vld_reg[i+1] <= sq_vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            sq_rad_reg[i+1]  <= sq_rad_reg[i];
            sq_rem_reg[i+1]  <= ge ? REM_W'(acc - trial) : REM_W'(acc);
            sq_root_reg[i+1] <= {sq_root_reg[i][RW-2:0], ge};
        end
    end

    // ---------------------------------------------------------------------
    // Divider entry: numerator = yield << FRACTION_BITS. Quotient overflows
    // 32 bits exactly when the upper numerator word is not below the root;
    // a zero root always overflows, which gives the saturated factor.
    // ---------------------------------------------------------------------
    logic [63:0]     numer;
    logic [RW-1:0]   root_fin;
    logic            sat_next;

    assign numer    = 64'(yield_reg) << FRACTION_BITS;
    assign root_fin = sq_root_reg[RW];
    assign sat_next = 34'(numer[63:32]) >= 34'(root_fin);

    logic                 dv_vld_reg  [DIV_STEPS+1];
    logic [RW-1:0]        dv_root_reg [DIV_STEPS+1];
    logic [RW-1:0]        dv_rem_reg  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] dv_lo_reg   [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] dv_q_reg    [DIV_STEPS+1];
    logic                 dv_sat_reg  [DIV_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else
            dv_vld_reg[0] <= sq_vld_reg[RW];
    end

    always_ff @(posedge clk)
    begin
        dv_root_reg[0] <= root_fin;
        dv_rem_reg[0]  <= RW'(numer[63:32]);
        dv_lo_reg[0]   <= numer[31:0];
        dv_q_reg[0]    <= '0;
        dv_sat_reg[0]  <= sat_next;
    end

    // Restoring division, one quotient bit per stage
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [RW:0] acc;
        logic [RW:0] dvs;
        logic        ge;

        always_comb
        begin
            acc = {dv_rem_reg[j], dv_lo_reg[j][DIV_STEPS-1-j]};
            dvs = {1'b0, dv_root_reg[j]};
            ge  = acc >= dvs;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[j+1] <= 1'b0;
            else
                dv_vld_reg[j+1] <= dv_vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            dv_root_reg[j+1] <= dv_root_reg[j];
            dv_rem_reg[j+1]  <= ge ? RW'(acc - dvs) : RW'(acc);
            dv_lo_reg[j+1]   <= dv_lo_reg[j];
            dv_q_reg[j+1]    <= {dv_q_reg[j][DIV_STEPS-2:0], ge};
            dv_sat_reg[j+1]  <= dv_sat_reg[j];
        end
    end

    // ---------------------------------------------------------------------
    // Output register: saturate the factor, flag zero stress
    // ---------------------------------------------------------------------
    logic         done_reg;
    vmsf_result_t result_reg, result_next;

    always_comb
    begin
        result_next.von_mises     = VM_W'(dv_root_reg[DIV_STEPS]);
        result_next.safety_factor = dv_sat_reg[DIV_STEPS] ? FACTOR_MAX
                                                          : dv_q_reg[DIV_STEPS];
        result_next.unbounded     = dv_root_reg[DIV_STEPS] == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_vld_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/vmsf_checker.sv -----
// vmsf_checker: port-level assertions for the von Mises unit, bound to the
// top level below. Depends on vmsf_pkg.
`default_nettype none

module vmsf_checker #(
    parameter int STRESS_BITS = 32
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input wire logic                   done,
    input wire vmsf_pkg::vmsf_result_t result
);
    import vmsf_pkg::*;

    localparam int LAT = STRESS_BITS + 39;

    // Every accepted item yields a result after the fixed latency
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted item produced no result");

    // No result without a matching accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without accepted item");

    // Zero stress flags unbounded and saturates the factor
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.unbounded) |->
            (result.von_mises == '0 && result.safety_factor == FACTOR_MAX))
        else $error("unbounded result inconsistent");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.von_mises == '0) |-> result.unbounded)
        else $error("zero stress not flagged");

endmodule

bind von_mises_safety_factor_unit vmsf_checker #(
    .STRESS_BITS(STRESS_BITS)
) u_vmsf_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

// ----- tb/von_mises_safety_factor_unit_tb.sv -----
// von_mises_safety_factor_unit_tb: stimulus, prediction and checking for the
// von Mises safety factor unit. Depends on vmsf_pkg and the unit's RTL.
`default_nettype none

module von_mises_safety_factor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vmsf_pkg::*;

    localparam int LATENCY     = 71;
    localparam int CYCLE_LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    vmsf_item_t   stress;
    logic         done;
    vmsf_result_t result;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;

    von_mises_safety_factor_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .stress    (stress),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Tensors waiting to be driven, and results predicted for accepted ones.
    vmsf_item_t   tensor_queue[$];
    vmsf_result_t predicted_results[$];

    logic [31:0] yield_reg;      // predictor's copy of the yield register
    int          idle_pct;       // sender gap percentage for the current phase
    bit          hold_sender;    // stops the driver while set
    bit          in_taken;       // item accepted at the last rising edge
    int          mismatch_count;
    int          accepted_count;
    int          checked_count;
    int          cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Exact von Mises and safety factor, worked out at full width.
    function automatic vmsf_result_t predict_stress(vmsf_item_t t, logic [31:0] yield_val);
        logic signed [67:0] d1, d2, d3;
        logic signed [67:0] sxy, syz, sxz;
        logic [67:0]  sum;
        logic [67:0]  half;
        logic [32:0]  root;
        logic [32:0]  cand;
        logic [65:0]  sq;
        logic [63:0]  quot;
        vmsf_result_t r;
        d1  = 68'(t.stress_xx) - 68'(t.stress_yy);
        d2  = 68'(t.stress_yy) - 68'(t.stress_zz);
        d3  = 68'(t.stress_zz) - 68'(t.stress_xx);
        sxy = 68'(t.shear_xy);
        syz = 68'(t.shear_yz);
        sxz = 68'(t.shear_xz);
        sum = 68'(d1 * d1) + 68'(d2 * d2) + 68'(d3 * d3)
            + 68'd6 * (68'(sxy * sxy) + 68'(syz * syz) + 68'(sxz * sxz));
        half = sum >> 1;
        root = '0;
        for (int b = 32; b >= 0; b--)
        begin
            cand = root | (33'd1 << b);
            sq = 66'(cand) * 66'(cand);
            if (68'(sq) <= half)
                root = cand;
        end
        r.von_mises = root;
        if (root == 0)
        begin
            r.unbounded = 1'b1;
            r.safety_factor = FACTOR_MAX;
        end
        else
        begin
            r.unbounded = 1'b0;
            quot = {16'd0, yield_val, 16'd0} / 64'(root);
            r.safety_factor = (quot > 64'hFFFF_FFFF) ? FACTOR_MAX : quot[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s at cycle %0d: got %0h want %0h", what, cycle_count, got, want);
        mismatch_count++;
    endtask

    // Append a tensor to the pending queue.
    task automatic add_tensor(vmsf_item_t t);
        tensor_queue = {tensor_queue, t};
    endtask

    // Driver: present the next tensor at the falling edge, advance on acceptance.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                predicted_results = {predicted_results, predict_stress(stress, yield_reg)};
                accepted_count++;
                void'(tensor_queue.pop_front());
            end
            if (tensor_queue.size() > 0 && !hold_sender
                && $urandom_range(99) >= idle_pct)
            begin
                start  <= 1'b1;
                stress <= tensor_queue[0];
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: sample done at the rising edge and check against the oldest prediction.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        in_taken    <= start && !busy;
        if (rst_n && done)
        begin
            if (predicted_results.size() == 0)
                report_mismatch("unexpected result", 64'(result), 64'd0);
            else
            begin
                vmsf_result_t want;
                want = predicted_results.pop_front();
                if (result.von_mises !== want.von_mises)
                    report_mismatch("von_mises", 64'(result.von_mises), 64'(want.von_mises));
                if (result.safety_factor !== want.safety_factor)
                    report_mismatch("safety_factor", 64'(result.safety_factor),
                                    64'(want.safety_factor));
                if (result.unbounded !== want.unbounded)
                    report_mismatch("unbounded", 64'(result.unbounded), 64'(want.unbounded));
                checked_count++;
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", predicted_results.size());
            $display("von_mises_safety_factor_unit_tb failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_stress();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000)) - 1000);
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: return 32'(($urandom() >> $urandom_range(31)) ^ {32{$urandom_range(1) == 1}});
            4: return 32'd0;
            default: return $urandom() >> $urandom_range(31);
        endcase
    endfunction

    function automatic vmsf_item_t random_tensor();
        vmsf_item_t t;
        t.stress_xx = rand_stress();
        t.stress_yy = ($urandom_range(7) == 0) ? t.stress_xx : rand_stress();
        t.stress_zz = ($urandom_range(7) == 0) ? t.stress_yy : rand_stress();
        t.shear_xy  = ($urandom_range(3) == 0) ? 32'd0 : rand_stress();
        t.shear_yz  = ($urandom_range(3) == 0) ? 32'd0 : rand_stress();
        t.shear_xz  = ($urandom_range(3) == 0) ? 32'd0 : rand_stress();
        return t;
    endfunction

    function automatic vmsf_item_t make_tensor(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                               logic [31:0] d, logic [31:0] e, logic [31:0] f);
        vmsf_item_t t;
        t = {a, b, c, d, e, f};
        return t;
    endfunction

    // Drain the pipeline, then write the yield register while the unit is idle.
    task automatic write_yield(logic [31:0] value);
        wait (tensor_queue.size() == 0 && predicted_results.size() == 0);
        repeat (LATENCY + 4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        yield_reg = value;
    endtask

    task automatic run_random(int count);
        repeat (count)
            add_tensor(random_tensor());
        wait (tensor_queue.size() == 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        stress = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        yield_reg = '0;
        idle_pct = 17;
        hold_sender = 1'b0;
        mismatch_count = 0;
        accepted_count = 0;
        checked_count = 0;
        cycle_count = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Reset yield of zero: zero factor for nonzero stress, unbounded for zero stress.
        add_tensor(make_tensor(0, 0, 0, 0, 0, 0));
        add_tensor(make_tensor(1000, 0, 0, 0, 0, 0));
        write_yield(32'd250_000_000);
        // Directed extremes: zero, hydrostatic, sign extremes, pure shear, tiny stress.
        add_tensor(make_tensor(0, 0, 0, 0, 0, 0));
        add_tensor(make_tensor(5000, 5000, 5000, 0, 0, 0));
        add_tensor(make_tensor(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        add_tensor(make_tensor(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        add_tensor(make_tensor(32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF, 1, 0));
        add_tensor(make_tensor(0, 0, 0, 1, 0, 0));
        add_tensor(make_tensor(1, 0, 0, 0, 0, 0));
        add_tensor(make_tensor(0, 0, 0, 0, 0, 32'h8000_0000));
        add_tensor(make_tensor(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        write_yield(32'hFFFF_FFFF);
        // Maximum yield: saturation on small stress, finite on large.
        add_tensor(make_tensor(1, 0, 0, 0, 0, 0));
        add_tensor(make_tensor(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0));
        add_tensor(make_tensor(32'h8000_0000, 32'h7FFF_FFFF, 0,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        add_tensor(make_tensor(0, 0, 0, 0, 0, 0));
        run_random(400);

        // Hold the sender until the pipeline has emptied, then resume.
        hold_sender = 1'b1;
        add_tensor(random_tensor());
        wait (predicted_results.size() == 0);
        hold_sender = 1'b0;

        write_yield(32'd1);
        idle_pct = 58;
        run_random(450);
        write_yield(32'd0);
        idle_pct = 0;
        run_random(300);
        write_yield($urandom());
        run_random(600);

        wait (predicted_results.size() == 0);
        repeat (LATENCY + 8) @(posedge clk);
        $display("covered %0d tensors, %0d results checked, yields zero to maximum",
                 accepted_count, checked_count);
        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("von_mises_safety_factor_unit_tb passed");
        else
            $display("von_mises_safety_factor_unit_tb failed");
        $finish;
    end
endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/vmsf_pkg.sv
hw/rtl/von_mises_safety_factor_unit.sv
hw/rtl/vmsf_checker.sv
tb/von_mises_safety_factor_unit_tb.sv
